@@ src/tpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared constants and types for the turtle path tracer: command codes,
// configuration register map, field widths and series divisors.
// ----------------------------------------------------------------------------
package tpt_pkg;

    // field widths of the command and segment channels
    localparam int SYMBOL_W = 8;
    localparam int OUT_W    = 32;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int STEP_W     = 24;
    localparam int ANGLE_W    = 16;

    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [SYMBOL_W-1:0]   symbol_t;
    typedef logic signed [OUT_W-1:0] out_coord_t;

    // register indexes
    localparam cfg_idx_t REG_START_X       = 3'd0;
    localparam cfg_idx_t REG_START_Y       = 3'd1;
    localparam cfg_idx_t REG_START_HEADING = 3'd2;
    localparam cfg_idx_t REG_TURN_STEP     = 3'd3;
    localparam cfg_idx_t REG_STEP_LENGTH   = 3'd4;

    // command codes
    localparam symbol_t SYM_LEFT  = 8'h2B;
    localparam symbol_t SYM_RIGHT = 8'h2D;

    // sine table generation: pi/2 in Q30 and the Taylor divisors (2n)(2n+1)
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int TAYLOR_TERMS = 12;
    localparam logic [12:1][9:0] TAYLOR_DIV = {
        10'd600, 10'd506, 10'd420, 10'd342, 10'd272, 10'd210,
        10'd156, 10'd110, 10'd72,  10'd42,  10'd20,  10'd6
    };

endpackage

@@ src/tpt_cmd_if.sv @@
// ----------------------------------------------------------------------------
// tpt_cmd_if
// Command channel: one turtle symbol per request, with the reload flag.
// ----------------------------------------------------------------------------
interface tpt_cmd_if
    import tpt_pkg::*;
();
    logic    valid;
    logic    ready;
    symbol_t symbol;
    logic    first;

    modport source (output valid, output symbol, output first, input ready);
    modport sink   (input valid, input symbol, input first, output ready);
endinterface

@@ src/tpt_seg_if.sv @@
// ----------------------------------------------------------------------------
// tpt_seg_if
// Segment channel: one drawn segment per request, with the running box.
// ----------------------------------------------------------------------------
interface tpt_seg_if
    import tpt_pkg::*;
();
    logic       valid;
    logic       ready;
    out_coord_t from_x;
    out_coord_t from_y;
    out_coord_t to_x;
    out_coord_t to_y;
    out_coord_t box_min_x;
    out_coord_t box_max_x;
    out_coord_t box_min_y;
    out_coord_t box_max_y;

    modport source (
        output valid, input ready,
        output from_x, output from_y, output to_x, output to_y,
        output box_min_x, output box_max_x, output box_min_y, output box_max_y
    );
    modport sink (
        input valid, output ready,
        input from_x, input from_y, input to_x, input to_y,
        input box_min_x, input box_max_x, input box_min_y, input box_max_y
    );
endinterface

@@ src/turtle_path_tracer.sv @@
// A draw command is taken into the command register, then moves to the segment register.
// Throughput: one command per cycle; the command register and the segment register
//   are updated in the same pass, so only a stalled segment holds the command stage.
// Turn commands are absorbed in the command stage and produce no segment.
// Reset: pen at the origin, heading 0, box at the origin, step length 1.0,
//   all other configuration registers zero, both channels empty.
// ----------------------------------------------------------------------------
// turtle_path_tracer
// Turtle graphics interpreter: turns the heading on '+' and '-', otherwise
// moves the pen one step along the heading and reports the segment with the
// bounding box of the path since the last reload. Q16.16 coordinates saturate.
// ----------------------------------------------------------------------------
module turtle_path_tracer
    import tpt_pkg::*;
#(
    parameter int COORD_BITS   = 32,
    parameter int HEADING_BITS = 16,
    parameter int SINE_ENTRIES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    tpt_cmd_if.sink    cmd,
    tpt_seg_if.source  seg,
    input  logic       cfg_we,
    input  cfg_idx_t   cfg_index,
    input  cfg_data_t  cfg_data
);

    localparam int WIDE  = ((COORD_BITS > OUT_W) ? COORD_BITS : OUT_W) + 2;
    localparam int IDX_W = $clog2(SINE_ENTRIES + 1);
    localparam int PROD_W = HEADING_BITS - 2 + IDX_W;
    localparam int HEXT_W = HEADING_BITS + ANGLE_W;

    localparam logic signed [WIDE-1:0] CMAX =
        {{(WIDE - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [WIDE-1:0] CMIN = ~CMAX;
    localparam logic [HEADING_BITS-1:0] QUARTER = {2'b01, {(HEADING_BITS - 2){1'b0}}};

    // quarter-wave sine table in Q1.15, one extra entry for the full-scale peak
    function automatic logic [SINE_ENTRIES:0][16:0] build_rom();
        logic [SINE_ENTRIES:0][16:0] rom;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] e;
        rom = '0;
        for (int k = 0; k < SINE_ENTRIES; k++)
        begin
            x    = 64'(k) * HALF_PI_Q30 / SINE_ENTRIES;
            term = x;
            sum  = x;
            for (int n = 1; n <= TAYLOR_TERMS; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'(TAYLOR_DIV[n]);
                if ((n % 2) == 1)
                    sum = (sum > term) ? sum - term : 64'd0;
                else
                    sum = sum + term;
            end
            e = (sum * 64'd32768 + (64'd1 << 29)) >> 30;
            if (e > 64'd32767)
                e = 64'd32767;
            rom[k] = e[16:0];
        end
        rom[SINE_ENTRIES] = 17'd32768;
        return rom;
    endfunction

    localparam logic [SINE_ENTRIES:0][16:0] SINE_ROM = build_rom();

    // sine of a heading, Q1.15 with sign
    function automatic logic signed [17:0] sine_of(input logic [HEADING_BITS-1:0] h);
        logic [HEADING_BITS-3:0] p;
        logic [PROD_W-1:0]       prod;
        logic [IDX_W-1:0]        i;
        logic [IDX_W-1:0]        idx;
        logic [16:0]             v;
        p    = h[HEADING_BITS-3:0];
        prod = PROD_W'(p) * PROD_W'(SINE_ENTRIES);
        i    = prod[PROD_W-1:HEADING_BITS-2];
        idx  = h[HEADING_BITS-2] ? IDX_W'(SINE_ENTRIES) - i : i;
        v    = SINE_ROM[idx];
        return h[HEADING_BITS-1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    // clamp to the coordinate range
    function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [WIDE-1:0] v);
        logic signed [WIDE-1:0] t;
        t = v;
        if (v > CMAX)
            t = CMAX;
        else if (v < CMIN)
            t = CMIN;
        return t[COORD_BITS-1:0];
    endfunction

    // low bits of a coordinate as carried on the segment channel
    function automatic out_coord_t to_out(input logic signed [COORD_BITS-1:0] c);
        logic signed [WIDE-1:0] t;
        t = WIDE'(c);
        return t[OUT_W-1:0];
    endfunction

    // heading-width view of a 16-bit angle register
    function automatic logic [HEADING_BITS-1:0] to_heading(input logic [ANGLE_W-1:0] a);
        logic [HEXT_W-1:0] t;
        t = {{HEADING_BITS{1'b0}}, a};
        return t[HEADING_BITS-1:0];
    endfunction

    // configuration registers
    logic signed [CFG_DATA_W-1:0] start_x_reg;
    logic signed [CFG_DATA_W-1:0] start_y_reg;
    logic [ANGLE_W-1:0]           start_heading_reg;
    logic [ANGLE_W-1:0]           turn_step_reg;
    logic [STEP_W-1:0]            step_length_reg;

    // command stage
    logic    in_valid_reg;
    symbol_t symbol_reg;
    logic    first_reg;

    // turtle state
    logic signed [COORD_BITS-1:0] pen_x_reg, pen_y_reg;
    logic signed [COORD_BITS-1:0] low_x_reg, high_x_reg, low_y_reg, high_y_reg;
    logic [HEADING_BITS-1:0]      heading_reg;

    // segment register
    logic       out_valid_reg;
    out_coord_t from_x_reg, from_y_reg, to_x_reg, to_y_reg;
    out_coord_t box_min_x_reg, box_max_x_reg, box_min_y_reg, box_max_y_reg;

    // datapath
    logic                         advance;
    logic                         is_turn;
    logic signed [COORD_BITS-1:0] cur_x, cur_y;
    logic signed [COORD_BITS-1:0] cur_low_x, cur_high_x, cur_low_y, cur_high_y;
    logic [HEADING_BITS-1:0]      cur_heading;
    logic [HEADING_BITS-1:0]      turn_h;
    logic signed [17:0]           cos_val, sin_val;
    logic signed [42:0]           prod_x, prod_y;
    logic signed [27:0]           dx, dy;
    logic signed [COORD_BITS-1:0] nx, ny;
    logic signed [COORD_BITS-1:0] pen_x_next, pen_y_next;
    logic signed [COORD_BITS-1:0] low_x_next, high_x_next, low_y_next, high_y_next;
    logic [HEADING_BITS-1:0]      heading_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            start_heading_reg <= '0;
            turn_step_reg     <= '0;
            step_length_reg   <= STEP_W'(65536);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_X:       start_x_reg       <= cfg_data;
                REG_START_Y:       start_y_reg       <= cfg_data;
                REG_START_HEADING: start_heading_reg <= cfg_data[ANGLE_W-1:0];
                REG_TURN_STEP:     turn_step_reg     <= cfg_data[ANGLE_W-1:0];
                REG_STEP_LENGTH:   step_length_reg   <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: turns never wait on the segment channel
    assign is_turn   = symbol_reg inside {SYM_LEFT, SYM_RIGHT};
    assign advance   = in_valid_reg && (is_turn || !out_valid_reg || seg.ready);
    assign cmd.ready = !in_valid_reg || advance;

    // command stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (cmd.ready)
            in_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            symbol_reg <= cmd.symbol;
            first_reg  <= cmd.first;
        end
    end

    // pose after an optional reload
    always_comb
    begin
        if (first_reg)
        begin
            cur_x       = sat(WIDE'(start_x_reg));
            cur_y       = sat(WIDE'(start_y_reg));
            cur_heading = to_heading(start_heading_reg);
            cur_low_x   = cur_x;
            cur_high_x  = cur_x;
            cur_low_y   = cur_y;
            cur_high_y  = cur_y;
        end
        else
        begin
            cur_x       = pen_x_reg;
            cur_y       = pen_y_reg;
            cur_heading = heading_reg;
            cur_low_x   = low_x_reg;
            cur_high_x  = high_x_reg;
            cur_low_y   = low_y_reg;
            cur_high_y  = high_y_reg;
        end
    end

    // move along the heading, floor-shifted products, saturated sums
    assign cos_val = sine_of(cur_heading + QUARTER);
    assign sin_val = sine_of(cur_heading);
    assign prod_x  = $signed({1'b0, step_length_reg}) * cos_val;
    assign prod_y  = $signed({1'b0, step_length_reg}) * sin_val;
    assign dx      = prod_x[42:15];
    assign dy      = prod_y[42:15];
    assign nx      = sat(WIDE'(cur_x) + WIDE'(dx));
    assign ny      = sat(WIDE'(cur_y) + WIDE'(dy));
    assign turn_h  = to_heading(turn_step_reg);

    // next turtle state
    always_comb
    begin
        pen_x_next   = cur_x;
        pen_y_next   = cur_y;
        heading_next = cur_heading;
        low_x_next   = cur_low_x;
        high_x_next  = cur_high_x;
        low_y_next   = cur_low_y;
        high_y_next  = cur_high_y;
        if (symbol_reg == SYM_LEFT)
            heading_next = cur_heading + turn_h;
        else if (symbol_reg == SYM_RIGHT)
            heading_next = cur_heading - turn_h;
        else
        begin
            pen_x_next  = nx;
            pen_y_next  = ny;
            low_x_next  = (nx < cur_low_x)  ? nx : cur_low_x;
            high_x_next = (nx > cur_high_x) ? nx : cur_high_x;
            low_y_next  = (ny < cur_low_y)  ? ny : cur_low_y;
            high_y_next = (ny > cur_high_y) ? ny : cur_high_y;
        end
    end

    // turtle state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg   <= '0;
            pen_y_reg   <= '0;
            heading_reg <= '0;
            low_x_reg   <= '0;
            high_x_reg  <= '0;
            low_y_reg   <= '0;
            high_y_reg  <= '0;
        end
        else if (advance)
        begin
            pen_x_reg   <= pen_x_next;
            pen_y_reg   <= pen_y_next;
            heading_reg <= heading_next;
            low_x_reg   <= low_x_next;
            high_x_reg  <= high_x_next;
            low_y_reg   <= low_y_next;
            high_y_reg  <= high_y_next;
        end
    end

    // segment register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && !is_turn)
            out_valid_reg <= 1'b1;
        else if (seg.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && !is_turn)
        begin
            from_x_reg    <= to_out(cur_x);
            from_y_reg    <= to_out(cur_y);
            to_x_reg      <= to_out(nx);
            to_y_reg      <= to_out(ny);
            box_min_x_reg <= to_out(low_x_next);
            box_max_x_reg <= to_out(high_x_next);
            box_min_y_reg <= to_out(low_y_next);
            box_max_y_reg <= to_out(high_y_next);
        end
    end

    assign seg.valid     = out_valid_reg;
    assign seg.from_x    = from_x_reg;
    assign seg.from_y    = from_y_reg;
    assign seg.to_x      = to_x_reg;
    assign seg.to_y      = to_y_reg;
    assign seg.box_min_x = box_min_x_reg;
    assign seg.box_max_x = box_max_x_reg;
    assign seg.box_min_y = box_min_y_reg;
    assign seg.box_max_y = box_max_y_reg;

    // the pen always lies inside the box
    assert property (@(posedge clk) disable iff (!rst_n)
        (low_x_reg <= pen_x_reg) && (pen_x_reg <= high_x_reg) &&
        (low_y_reg <= pen_y_reg) && (pen_y_reg <= high_y_reg))
        else $error("pen outside bounding box");

    // a draw command always lands in the segment register
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !is_turn) |=> out_valid_reg)
        else $error("draw command lost");

    // a turn command adds no segment
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_turn && !(out_valid_reg && !seg.ready)) |=> !out_valid_reg)
        else $error("turn command produced a segment");

    // a held command is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(symbol_reg)
            && $stable(first_reg)))
        else $error("held command overwritten");

endmodule

@@ tb/sv/tb_turtle_path_tracer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_turtle_path_tracer
// Self-checking bench for the turtle path tracer. A short scripted walk hits
// the register extremes, both turn commands, reloads and saturation in both
// directions. Random command strings then run under four idling patterns on
// the command and segment channels. Every segment is checked field by field
// against an in-bench model of pen, heading and box, or against given script values.
// ----------------------------------------------------------------------------
module tb_turtle_path_tracer;
    import tpt_pkg::*;

    localparam int TABLE_SIZE     = 256;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PROGRAM_ITEMS  = 216;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
    localparam symbol_t SYM_DRAW = 8'h46;

    localparam out_coord_t ORIGIN = 32'sd0;
    localparam out_coord_t ONE    = 32'sd65536;
    localparam out_coord_t CMAX   = 32'sh7FFF_FFFF;
    localparam out_coord_t CMIN   = 32'sh8000_0000;

    typedef struct packed {
        out_coord_t from_x;
        out_coord_t from_y;
        out_coord_t to_x;
        out_coord_t to_y;
        out_coord_t box_min_x;
        out_coord_t box_max_x;
        out_coord_t box_min_y;
        out_coord_t box_max_y;
    } segment_t;

    typedef enum logic {ROW_REG, ROW_CMD} row_kind_t;

    typedef struct {
        row_kind_t kind;
        cfg_idx_t  index;
        cfg_data_t data;
        symbol_t   symbol;
        logic      first;
        bit        given;
        segment_t  seg;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    cfg_idx_t cfg_index;
    cfg_data_t cfg_data;

    tpt_cmd_if cmd_bus ();
    tpt_seg_if seg_bus ();

    turtle_path_tracer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_bus),
        .seg       (seg_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // turtle model state and its copy of the registers
    int unsigned sine_rom [TABLE_SIZE];
    out_coord_t start_x = '0;
    out_coord_t start_y = '0;
    logic [ANGLE_W-1:0] start_heading = '0;
    logic [ANGLE_W-1:0] turn_step = '0;
    logic [STEP_W-1:0] step_len = 24'd65536;
    out_coord_t pen_x = '0;
    out_coord_t pen_y = '0;
    out_coord_t low_x = '0;
    out_coord_t high_x = '0;
    out_coord_t low_y = '0;
    out_coord_t high_y = '0;
    logic [ANGLE_W-1:0] heading = '0;

    segment_t due_segments [$];
    segment_t due;
    stim_row_t script [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int commands = 0;
    int segments_checked = 0;
    int settings = 0;
    int quiet_cycles = 0;

    // 10 ns clock
    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    // quarter-wave lookup, signed Q1.15
    function automatic int sine_at(logic [ANGLE_W-1:0] h);
        logic [1:0] quad;
        int unsigned idx;
        int unsigned slot;
        int mag;
        quad = h[ANGLE_W-1 -: 2];
        idx  = h[ANGLE_W-3:0] >> 6;
        slot = quad[0] ? TABLE_SIZE - idx : idx;
        mag  = (slot >= TABLE_SIZE) ? 32768 : int'(sine_rom[slot]);
        return quad[1] ? -mag : mag;
    endfunction

    // step length times trig value, floor shift back to Q16.16
    function automatic longint stride(int trig);
        longint prod;
        prod = longint'(step_len) * longint'(trig);
        return prod >>> 15;
    endfunction

    function automatic out_coord_t clamp(longint v);
        if (v > 64'sd2147483647)
            return CMAX;
        if (v < -64'sd2147483648)
            return CMIN;
        return out_coord_t'(v);
    endfunction

    // apply one command to the turtle; returns 1 when a segment is drawn
    function automatic bit advance_pen(symbol_t sym, logic first, output segment_t seg);
        out_coord_t nx;
        out_coord_t ny;
        seg = '0;
        if (first)
        begin
            pen_x   = start_x;
            pen_y   = start_y;
            heading = start_heading;
            low_x   = start_x;
            high_x  = start_x;
            low_y   = start_y;
            high_y  = start_y;
        end
        if (sym == SYM_LEFT)
        begin
            heading = heading + turn_step;
            return 1'b0;
        end
        if (sym == SYM_RIGHT)
        begin
            heading = heading - turn_step;
            return 1'b0;
        end
        nx = clamp(longint'(pen_x) + stride(sine_at(heading + QUARTER_TURN)));
        ny = clamp(longint'(pen_y) + stride(sine_at(heading)));
        if (nx < low_x)
            low_x = nx;
        if (nx > high_x)
            high_x = nx;
        if (ny < low_y)
            low_y = ny;
        if (ny > high_y)
            high_y = ny;
        seg = '{from_x: pen_x, from_y: pen_y, to_x: nx, to_y: ny,
                box_min_x: low_x, box_max_x: high_x, box_min_y: low_y, box_max_y: high_y};
        pen_x = nx;
        pen_y = ny;
        return 1'b1;
    endfunction

    function automatic void match_field(string name, out_coord_t want, out_coord_t got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic stim_row_t reg_row(cfg_idx_t idx, cfg_data_t data);
        stim_row_t r;
        r.kind   = ROW_REG;
        r.index  = idx;
        r.data   = data;
        r.symbol = '0;
        r.first  = 1'b0;
        r.given  = 1'b0;
        r.seg    = '0;
        return r;
    endfunction

    function automatic stim_row_t cmd_row(symbol_t sym, logic first, bit given = 1'b0,
                                          segment_t seg = '0);
        stim_row_t r;
        r.kind   = ROW_CMD;
        r.index  = '0;
        r.data   = '0;
        r.symbol = sym;
        r.first  = first;
        r.given  = given;
        r.seg    = seg;
        return r;
    endfunction

    function automatic cfg_data_t pick_coord();
        case ($urandom_range(4))
            0: return CMAX;
            1: return CMIN;
            2: return ORIGIN;
            3: return $urandom;
            default: return cfg_data_t'(int'($urandom_range(200 * 65536)) - 100 * 65536);
        endcase
    endfunction

    function automatic cfg_data_t pick_angle();
        case ($urandom_range(4))
            0: return 32'h0000;
            1: return 32'hFFFF;
            2: return 32'h4000;
            3: return 32'h2000;
            default: return $urandom_range(16'hFFFF);
        endcase
    endfunction

    // register write on an idle block; the model copy follows at once
    task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_START_X:       start_x = data;
            REG_START_Y:       start_y = data;
            REG_START_HEADING: start_heading = data[ANGLE_W-1:0];
            REG_TURN_STEP:     turn_step = data[ANGLE_W-1:0];
            REG_STEP_LENGTH:   step_len = data[STEP_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // drop valid and let every pending segment and any turn in flight clear
    task automatic wait_idle();
        cmd_bus.valid <= 1'b0;
        while (due_segments.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one command request, with random idle cycles ahead of it
    task automatic send_cmd(symbol_t sym, logic first, bit given = 1'b0,
                            segment_t given_seg = '0);
        segment_t seg;
        bit drawn;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid  <= 1'b1;
        cmd_bus.symbol <= sym;
        cmd_bus.first  <= first;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        drawn = advance_pen(sym, first, seg);
        if (drawn)
            due_segments.push_back(given ? given_seg : seg);
        commands++;
    endtask

    task automatic randomize_regs();
        cfg_data_t length;
        wait_idle();
        case ($urandom_range(5))
            0: length = 32'hFF_FFFF;
            1: length = '0;
            2: length = $urandom_range(24'hFF_FFFF);
            default: length = $urandom_range(1 << 20);
        endcase
        write_reg(REG_START_X, pick_coord());
        write_reg(REG_START_Y, pick_coord());
        write_reg(REG_START_HEADING, pick_angle());
        write_reg(REG_TURN_STEP, pick_angle());
        write_reg(REG_STEP_LENGTH, length);
        settings++;
    endtask

    // command strings that open with a reload, plus some loose noise
    task automatic run_programs(int count);
        int sent;
        int len;
        int pick;
        symbol_t sym;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_cmd(symbol_t'($urandom_range(255)), logic'($urandom_range(1)));
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 40);
                for (int i = 0; i < len && sent < count; i++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 45)
                        sym = SYM_DRAW;
                    else if (pick < 60)
                        sym = symbol_t'($urandom_range(255));
                    else if (pick < 80)
                        sym = SYM_LEFT;
                    else
                        sym = SYM_RIGHT;
                    send_cmd(sym, (i == 0) || ($urandom_range(99) < 3));
                    sent++;
                end
            end
        end
    endtask

    // segment side: random stalls, check each accepted request
    always @(posedge clk)
    begin
        if (rst_n && seg_bus.valid && seg_bus.ready)
        begin
            if (due_segments.size() == 0)
            begin
                $error("segment request with no draw command pending");
                mismatches++;
            end
            else
            begin
                due = due_segments.pop_front();
                match_field("from_x", due.from_x, seg_bus.from_x);
                match_field("from_y", due.from_y, seg_bus.from_y);
                match_field("to_x", due.to_x, seg_bus.to_x);
                match_field("to_y", due.to_y, seg_bus.to_y);
                match_field("box_min_x", due.box_min_x, seg_bus.box_min_x);
                match_field("box_max_x", due.box_max_x, seg_bus.box_max_x);
                match_field("box_min_y", due.box_min_y, seg_bus.box_min_y);
                match_field("box_max_y", due.box_max_y, seg_bus.box_max_y);
                segments_checked++;
            end
        end
        seg_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles where neither channel moves a request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_bus.valid && cmd_bus.ready) || (seg_bus.valid && seg_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no request moved for %0d cycles, %0d segments pending",
                         quiet_cycles, due_segments.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin : main
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned rounded;
        int idle_plan [4];
        int stall_plan [4];

        idle_plan  = '{0, 54, 0, 8};
        stall_plan = '{0, 0, 54, 8};

        // quarter-wave sine table by Taylor series in Q30
        for (int k = 0; k < TABLE_SIZE; k++)
        begin
            x = longint'(k) * HALF_PI_Q30 / TABLE_SIZE;
            term = x;
            sum = x;
            for (int n = 1; n <= 12; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    sum = (sum > term) ? sum - term : 0;
                else
                    sum = sum + term;
            end
            rounded = (sum * 32768 + (64'd1 << 29)) >> 30;
            sine_rom[k] = (rounded > 32767) ? 32767 : int'(rounded);
        end

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        cmd_bus.valid  = 1'b0;
        cmd_bus.symbol = '0;
        cmd_bus.first  = 1'b0;
        seg_bus.ready  = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: unit step along +x from the origin
        script.push_back(cmd_row(SYM_DRAW, 1'b0, 1'b1,
            {ORIGIN, ORIGIN, ONE, ORIGIN, ORIGIN, ONE, ORIGIN, ORIGIN}));
        script.push_back(cmd_row(SYM_LEFT, 1'b0));
        script.push_back(cmd_row(SYM_RIGHT, 1'b1));
        script.push_back(cmd_row(8'h00, 1'b0, 1'b1,
            {ORIGIN, ORIGIN, ONE, ORIGIN, ORIGIN, ONE, ORIGIN, ORIGIN}));
        script.push_back(cmd_row(SYM_LEFT + 8'd1, 1'b0));
        // start at the bottom right corner, longest step, quarter turns
        script.push_back(reg_row(REG_START_X, CMAX));
        script.push_back(reg_row(REG_START_Y, CMIN));
        script.push_back(reg_row(REG_TURN_STEP, 32'h4000));
        script.push_back(reg_row(REG_STEP_LENGTH, 32'hFF_FFFF));
        script.push_back(cmd_row(8'hFF, 1'b1, 1'b1,
            {CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMIN}));
        script.push_back(cmd_row(SYM_LEFT, 1'b0));
        script.push_back(cmd_row(SYM_DRAW, 1'b0));
        script.push_back(cmd_row(SYM_LEFT, 1'b0));
        script.push_back(cmd_row(SYM_LEFT, 1'b0));
        script.push_back(cmd_row(SYM_RIGHT + 8'd1, 1'b0));
        script.push_back(cmd_row(SYM_RIGHT, 1'b0));
        script.push_back(cmd_row(SYM_DRAW, 1'b0));
        // opposite corner, heading a half turn, zero step, largest turn
        script.push_back(reg_row(REG_START_X, CMIN));
        script.push_back(reg_row(REG_START_Y, CMAX));
        script.push_back(reg_row(REG_START_HEADING, 32'h8000));
        script.push_back(reg_row(REG_TURN_STEP, 32'hFFFF));
        script.push_back(reg_row(REG_STEP_LENGTH, '0));
        script.push_back(cmd_row(8'h41, 1'b1, 1'b1,
            {CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX}));
        script.push_back(cmd_row(SYM_LEFT, 1'b0));
        script.push_back(cmd_row(SYM_DRAW, 1'b0));
        // longest step pointing at -x saturates low
        script.push_back(reg_row(REG_STEP_LENGTH, 32'hFF_FFFF));
        script.push_back(cmd_row(SYM_RIGHT, 1'b1));
        script.push_back(cmd_row(8'h7F, 1'b0));
        script.push_back(cmd_row(SYM_DRAW, 1'b1, 1'b1,
            {CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX}));
        script.push_back(cmd_row(SYM_RIGHT, 1'b0));
        script.push_back(cmd_row(SYM_DRAW, 1'b0));

        foreach (script[i])
        begin
            if (script[i].kind == ROW_REG)
            begin
                wait_idle();
                write_reg(script[i].index, script[i].data);
            end
            else
                send_cmd(script[i].symbol, script[i].first, script[i].given, script[i].seg);
        end
        settings += 3;

        // random command strings under each idling pattern
        for (int m = 0; m < 4; m++)
        begin
            send_idle_pct  = idle_plan[m];
            recv_stall_pct = stall_plan[m];
            for (int s = 0; s < 2; s++)
            begin
                randomize_regs();
                run_programs(PROGRAM_ITEMS);
            end
        end

        wait_idle();
        repeat (2 * DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d commands, %0d segments checked, %0d register settings",
                 commands, segments_checked, settings);
        $display("idling covered: none, sender 54%%, receiver 54%%, both 8%%");
        if (mismatches == 0 && due_segments.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
src/tpt_pkg.sv
src/tpt_cmd_if.sv
src/tpt_seg_if.sv
src/turtle_path_tracer.sv
tb/sv/tb_turtle_path_tracer.sv
